// ===== hdl/lfsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsd_pkg
// Shared constants and controller/datapath interface types for the lidar
// frame sync decoder.
// ----------------------------------------------------------------------------
package lfsd_pkg;

    localparam int FRAME_BYTES  = 28;
    localparam int CHECK_OFFSET = 26;
    localparam int POINTS       = 8;
    localparam int CHECK_BITS   = 15;
    localparam int ACC_BITS     = 16 + CHECK_OFFSET / 2;
    localparam int POS_BITS     = 5;
    localparam int PT_BITS      = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [POS_BITS-1:0] pos_t;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_HEADER0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEADER1  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERSION  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PTYPE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_MASK = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIST_MASK = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // byte transfer on the input channel
        logic sweep;      // read out the stored frame
        logic good;       // checksum passed, arm emission
        logic bad;        // checksum failed, arm resync search
        logic search;     // test one slide offset
        logic emit_step;  // result transfer on the output channel
    } lfsd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic completes;    // accepted byte fills the frame
        logic sweep_done;   // last stored byte processed
        logic csum_ok;      // computed checksum equals received word
        logic search_done;  // slide offset found or exhausted
        logic emit_last;    // current result is the eighth point
    } lfsd_status_t;

endpackage : lfsd_pkg
`default_nettype wire

// ===== hdl/lidar_frame_sync_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_frame_sync_decoder
// Resynchronising 28-byte lidar frame decoder with folded checksum check.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, data_byte) takes one serial byte per
// transfer. The byte that completes a frame starts a read-out of the
// 28-byte frame memory, one byte per cycle through its single read port,
// followed by a checksum decision state.
// Good frame: eight point results leave on the output channel
// (out_valid/out_stall), one per cycle when not stalled, last on the eighth.
// Bad frame: the slide search tests one offset per cycle, offsets 1 to 27.
// The input is stalled from the completing byte until the frame is fully
// handled, so no new byte is taken while a frame is in hand.
// A stalled result holds all its fields. Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect at once and are expected while idle.
// Reset returns the registers to their defaults, empties the frame and
// clears both counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lidar_frame_sync_decoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [lfsd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [lfsd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          data_byte,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [15:0]                              motor_speed,
    output logic [15:0]                              start_angle,
    output logic [15:0]                              end_angle,
    output logic [lfsd_pkg::CHECK_BITS-1:0]          check_word,
    output logic [lfsd_pkg::PT_BITS-1:0]             point_index,
    output logic [15:0]                              distance,
    output logic                                     point_valid,
    output logic                                     last,
    output logic [31:0]                              resync_count,
    output logic [31:0]                              checksum_error_count
);
    import lfsd_pkg::*;

    lfsd_cmd_t    cmd;
    lfsd_status_t status;

    // Sequence control
    lfsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    lfsd_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .data_byte            (data_byte),
        .cmd                  (cmd),
        .status               (status),
        .motor_speed          (motor_speed),
        .start_angle          (start_angle),
        .end_angle            (end_angle),
        .check_word           (check_word),
        .point_index          (point_index),
        .distance             (distance),
        .point_valid          (point_valid),
        .last                 (last),
        .resync_count         (resync_count),
        .checksum_error_count (checksum_error_count)
    );

endmodule : lidar_frame_sync_decoder
`default_nettype wire

// ===== hdl/lfsd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsd_ctrl
// Frame sequencer: byte intake, frame sweep, checksum decision, resync
// search and point emission.
// ----------------------------------------------------------------------------
module lfsd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire lfsd_pkg::lfsd_status_t status,
    output lfsd_pkg::lfsd_cmd_t        cmd
);
    import lfsd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DECIDE,
        S_SEARCH,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, out_valid_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.sweep     = (state_reg == S_SWEEP);
        cmd.good      = (state_reg == S_DECIDE) && status.csum_ok;
        cmd.bad       = (state_reg == S_DECIDE) && !status.csum_ok;
        cmd.search    = (state_reg == S_SEARCH);
        cmd.emit_step = (state_reg == S_EMIT) && !out_stall;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && status.completes)
                    state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                if (status.sweep_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = status.csum_ok ? S_EMIT : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (status.search_done)
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (cmd.emit_step && status.emit_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= (state_next != S_IDLE);
            out_valid_reg <= (state_next == S_EMIT);
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

endmodule : lfsd_ctrl
`default_nettype wire

// ===== hdl/lfsd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsd_datapath
// Circular frame memory, serial checksum fold, field capture, resync
// search over slide offsets, counters and result fields.
// ----------------------------------------------------------------------------
module lfsd_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [lfsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [lfsd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic [7:0]                            data_byte,
    input  wire lfsd_pkg::lfsd_cmd_t                   cmd,
    output lfsd_pkg::lfsd_status_t                     status,
    output logic [15:0]                                motor_speed,
    output logic [15:0]                                start_angle,
    output logic [15:0]                                end_angle,
    output logic [lfsd_pkg::CHECK_BITS-1:0]            check_word,
    output logic [lfsd_pkg::PT_BITS-1:0]               point_index,
    output logic [15:0]                                distance,
    output logic                                       point_valid,
    output logic                                       last,
    output logic [31:0]                                resync_count,
    output logic [31:0]                                checksum_error_count
);
    import lfsd_pkg::*;

    localparam pos_t LAST_POS  = pos_t'(FRAME_BYTES - 1);
    localparam pos_t FULL_POS  = pos_t'(FRAME_BYTES);
    localparam pos_t CHK_LO    = pos_t'(CHECK_OFFSET);
    localparam pos_t PT_FIRST  = 5'd8;
    localparam pos_t PT_END    = 5'd23;

    // Map a logical frame position onto the circular memory
    function automatic pos_t phys(input pos_t base, input pos_t p);
        logic [POS_BITS:0] s;
        s = {1'b0, base} + {1'b0, p};
        if (s >= (POS_BITS+1)'(FRAME_BYTES))
            s = s - (POS_BITS+1)'(FRAME_BYTES);
        return s[POS_BITS-1:0];
    endfunction

    // Configuration registers
    logic [7:0]  hdr0_reg, hdr1_reg, ver_reg, ptype_reg;
    logic [15:0] inv_mask_reg, dist_mask_reg;

    // Frame memory and pointers
    logic [7:0]  mem [FRAME_BYTES];
    logic [7:0]  rd_data_reg;
    pos_t        base_reg, fill_reg;
    pos_t        rp_reg, dp_reg;
    logic        dv_reg;

    // Sweep capture
    logic [ACC_BITS-1:0] acc_reg;
    logic [7:0]          lo_reg;
    logic [15:0]         chk_reg, motor_reg, start_reg, end_reg;
    logic [15:0]         pts [POINTS];
    logic [FRAME_BYTES-1:0] m0_reg, m1_reg, m2_reg, m3_reg;

    // Search, emission and counters
    pos_t                k_reg;
    logic [PT_BITS-1:0]  pi_reg;
    logic [31:0]         resync_reg, bad_reg;

    logic [7:0]  expect_byte;
    logic        byte_ok;
    logic [15:0] word;
    logic [15:0] fold_sum;
    pos_t        k1, k2, k3;
    logic        hit;
    pos_t        k_final;
    logic [PT_BITS-1:0] pt_slot;

    // Expected byte for the next prefix position
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    expect_byte = hdr0_reg;
            2'd1:    expect_byte = hdr1_reg;
            2'd2:    expect_byte = ver_reg;
            default: expect_byte = ptype_reg;
        endcase
    end

    assign byte_ok = (fill_reg >= 5'd4) || (data_byte == expect_byte);
    assign word    = {rd_data_reg, lo_reg};
    assign pt_slot = PT_BITS'((dp_reg - PT_FIRST) >> 1);

    // Fold the accumulator into 15 bits
    assign fold_sum = {1'b0, acc_reg[CHECK_BITS-1:0]}
                    + 16'(acc_reg[ACC_BITS-1:CHECK_BITS]);

    // Test the current slide offset against the prefix flags
    assign k1 = k_reg + 5'd1;
    assign k2 = k_reg + 5'd2;
    assign k3 = k_reg + 5'd3;
    assign hit = m0_reg[k_reg]
               && ((k1 > LAST_POS) || m1_reg[k1])
               && ((k2 > LAST_POS) || m2_reg[k2])
               && ((k3 > LAST_POS) || m3_reg[k3]);
    assign k_final = hit ? k_reg : FULL_POS;

    always_comb
    begin
        status             = '0;
        status.completes   = byte_ok && (fill_reg == LAST_POS);
        status.sweep_done  = dv_reg && (dp_reg == LAST_POS);
        status.csum_ok     = ({1'b0, fold_sum[CHECK_BITS-1:0]} == chk_reg);
        status.search_done = hit || (k_reg == LAST_POS);
        status.emit_last   = (pi_reg == PT_BITS'(POINTS - 1));
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr0_reg      <= 8'h55;
            hdr1_reg      <= 8'hAA;
            ver_reg       <= 8'h02;
            ptype_reg     <= 8'h08;
            inv_mask_reg  <= 16'h8000;
            dist_mask_reg <= 16'h3FFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HEADER0:   hdr0_reg      <= cfg_data[7:0];
                REG_HEADER1:   hdr1_reg      <= cfg_data[7:0];
                REG_VERSION:   ver_reg       <= cfg_data[7:0];
                REG_PTYPE:     ptype_reg     <= cfg_data[7:0];
                REG_INV_MASK:  inv_mask_reg  <= cfg_data;
                REG_DIST_MASK: dist_mask_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Frame memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (byte_ok || data_byte == hdr0_reg))
            mem[phys(base_reg, byte_ok ? fill_reg : 5'd0)] <= data_byte;
        rd_data_reg <= mem[phys(base_reg, rp_reg)];
    end

    // Control state: fill, base, sweep pointers, search and emit counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            base_reg   <= '0;
            rp_reg     <= '0;
            dp_reg     <= '0;
            dv_reg     <= 1'b0;
            k_reg      <= 5'd1;
            pi_reg     <= '0;
            resync_reg <= '0;
            bad_reg    <= '0;
        end
        else
        begin
            dv_reg <= 1'b0;
            if (cmd.accept)
            begin
                rp_reg <= '0;
                if (byte_ok)
                    fill_reg <= fill_reg + 5'd1;
                else
                begin
                    // drop the partial frame, keep a fresh header byte
                    resync_reg <= resync_reg + 32'(fill_reg) + 32'd1;
                    fill_reg   <= (data_byte == hdr0_reg) ? 5'd1 : 5'd0;
                end
            end
            if (cmd.sweep && !dv_reg || cmd.sweep && dp_reg != LAST_POS)
            begin
                if (rp_reg != FULL_POS)
                begin
                    rp_reg <= rp_reg + 5'd1;
                    dp_reg <= rp_reg;
                    dv_reg <= 1'b1;
                end
            end
            if (cmd.good)
            begin
                fill_reg <= '0;
                pi_reg   <= '0;
            end
            if (cmd.bad)
            begin
                bad_reg <= bad_reg + 32'd1;
                k_reg   <= 5'd1;
            end
            if (cmd.search)
            begin
                k_reg <= k_reg + 5'd1;
                if (status.search_done)
                begin
                    // slide to the next offset that still reads as a prefix
                    resync_reg <= resync_reg + 32'(k_final);
                    fill_reg   <= FULL_POS - k_final;
                    base_reg   <= phys(base_reg, hit ? k_reg : 5'd0);
                end
            end
            if (cmd.emit_step)
                pi_reg <= pi_reg + PT_BITS'(1);
        end
    end

    // Capture words and prefix flags as the frame streams past
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            acc_reg <= '0;
        if (dv_reg)
        begin
            m0_reg[dp_reg] <= (rd_data_reg == hdr0_reg);
            m1_reg[dp_reg] <= (rd_data_reg == hdr1_reg);
            m2_reg[dp_reg] <= (rd_data_reg == ver_reg);
            m3_reg[dp_reg] <= (rd_data_reg == ptype_reg);
            if (!dp_reg[0])
                lo_reg <= rd_data_reg;
            else
            begin
                if (dp_reg < CHK_LO)
                    acc_reg <= {acc_reg[ACC_BITS-2:0], 1'b0} + ACC_BITS'(word);
                if (dp_reg == 5'd5)
                    motor_reg <= word;
                if (dp_reg == 5'd7)
                    start_reg <= word;
                if (dp_reg == 5'd25)
                    end_reg <= word;
                if (dp_reg == LAST_POS)
                    chk_reg <= word;
                if (dp_reg > PT_FIRST && dp_reg <= PT_END)
                    pts[pt_slot] <= word;
            end
        end
    end

    // Result fields, stable while the output is stalled
    assign motor_speed          = motor_reg;
    assign start_angle          = start_reg;
    assign end_angle            = end_reg;
    assign check_word           = chk_reg[CHECK_BITS-1:0];
    assign point_index          = pi_reg;
    assign distance             = pts[pi_reg] & dist_mask_reg;
    assign point_valid          = ((pts[pi_reg] & inv_mask_reg) == 16'd0);
    assign last                 = status.emit_last;
    assign resync_count         = resync_reg;
    assign checksum_error_count = bad_reg;

endmodule : lfsd_datapath
`default_nettype wire

// ===== test/lidar_frame_sync_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_sync_decoder_tb
// Feeds byte streams of good, damaged and truncated frames mixed with line
// noise under several header and mask settings, predicts every point result
// and both error counters, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module lidar_frame_sync_decoder_tb;
    import lfsd_pkg::*;

    typedef struct packed {
        logic [15:0] speed;
        logic [15:0] ang_start;
        logic [15:0] ang_end;
        logic [14:0] csum;
        logic [2:0]  idx;
        logic [15:0] dist_val;
        logic        pvalid;
        logic        plast;
        logic [31:0] resyncs;
        logic [31:0] bad_frames;
    } point_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] motor_speed, start_angle, end_angle, distance;
    logic [14:0] check_word;
    logic [2:0]  point_index;
    logic        point_valid, last;
    logic [31:0] resync_count, checksum_error_count;

    // decoder mirror: settings and frame state
    logic [7:0]  hdr [4];
    logic [15:0] inv_mask, dist_mask;
    logic [7:0]  held [FRAME_BYTES];
    int          held_fill;
    logic [31:0] resync_total, bad_total;

    logic [7:0] byte_fifo [$];
    point_t     points_due [$];
    int         errors = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    int         hold_token = 0;
    int         hold_seen = 0;
    bit         burst = 0;

    lidar_frame_sync_decoder i_dut (.*);

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit prefix_ok(int pos, logic [7:0] b);
        return (pos > 3) || (b == hdr[pos]);
    endfunction

    function automatic logic [15:0] le_word(int pos);
        return {held[(pos + 1) % FRAME_BYTES], held[pos % FRAME_BYTES]};
    endfunction

    function automatic logic [14:0] fold_sum(logic [7:0] f [FRAME_BYTES]);
        logic [31:0] acc;
        acc = 32'd0;
        for (int i = 0; i < CHECK_OFFSET; i += 2)
            acc = (acc << 1) + {16'h0000, f[i + 1], f[i]};
        return 15'((acc & 32'h7FFF) + (acc >> 15));
    endfunction

    // Advance the mirror by one accepted byte and queue any points it yields
    task automatic absorb_byte(logic [7:0] b);
        point_t p;
        logic [15:0] w;
        int k, n;
        if (held_fill >= FRAME_BYTES) held_fill = 0;
        if (!prefix_ok(held_fill, b)) begin
            resync_total += 32'(held_fill + 1);
            if (b == hdr[0]) begin
                held[0] = b;
                held_fill = 1;
            end else begin
                held_fill = 0;
            end
            return;
        end
        held[held_fill] = b;
        held_fill++;
        if (held_fill < FRAME_BYTES) return;
        if ({1'b0, fold_sum(held)} == le_word(CHECK_OFFSET)) begin
            held_fill = 0;
            for (int i = 0; i < POINTS; i++) begin
                w = le_word(8 + 2 * i);
                p.speed      = le_word(4);
                p.ang_start  = le_word(6);
                p.ang_end    = le_word(24);
                p.csum       = 15'(le_word(CHECK_OFFSET));
                p.idx        = 3'(i);
                p.dist_val   = w & dist_mask;
                p.pvalid     = (w & inv_mask) == 16'd0;
                p.plast      = (i == POINTS - 1);
                p.resyncs    = resync_total;
                p.bad_frames = bad_total;
                points_due.push_back(p);
            end
            return;
        end
        // slide to the nearest offset that still reads as a valid prefix
        bad_total++;
        for (k = 1; k < FRAME_BYTES; k++) begin
            n = 0;
            while (k + n < FRAME_BYTES && prefix_ok(n, held[k + n])) n++;
            if (k + n == FRAME_BYTES) break;
        end
        resync_total += 32'(k);
        held_fill = FRAME_BYTES - k;
        for (int i = 0; i < held_fill; i++) held[i] = held[i + k];
    endtask

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // Sender: hold a stalled byte, otherwise wait out the gap and load the next
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) absorb_byte(data_byte);
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (byte_fifo.size() > 0) begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_fifo.pop_front();
                    send_gap  = draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Receiver: check each result transfer, then draw the next stall
    always @(posedge clk) begin
        point_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (points_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, point %0d", $time, point_index);
                end else begin
                    want = points_due.pop_front();
                    check_field("motor_speed", want.speed, motor_speed);
                    check_field("start_angle", want.ang_start, start_angle);
                    check_field("end_angle", want.ang_end, end_angle);
                    check_field("check_word", want.csum, check_word);
                    check_field("point_index", want.idx, point_index);
                    check_field("distance", want.dist_val, distance);
                    check_field("point_valid", want.pvalid, point_valid);
                    check_field("last", want.plast, last);
                    check_field("resync_count", want.resyncs, resync_count);
                    check_field("checksum_error_count", want.bad_frames,
                                checksum_error_count);
                end
                recv_gap = draw_gap();
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = 400;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            out_stall <= (recv_gap > 0) || (hold_left > 0);
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_HEADER0:   hdr[0] = val[7:0];
            REG_HEADER1:   hdr[1] = val[7:0];
            REG_VERSION:   hdr[2] = val[7:0];
            REG_PTYPE:     hdr[3] = val[7:0];
            REG_INV_MASK:  inv_mask = val;
            REG_DIST_MASK: dist_mask = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(logic [7:0] h0, logic [7:0] h1, logic [7:0] ver,
                             logic [7:0] pt, logic [15:0] im, logic [15:0] dm);
        write_reg(REG_HEADER0, {8'h00, h0});
        write_reg(REG_HEADER1, {8'h00, h1});
        write_reg(REG_VERSION, {8'h00, ver});
        write_reg(REG_PTYPE, {8'h00, pt});
        write_reg(REG_INV_MASK, im);
        write_reg(REG_DIST_MASK, dm);
    endtask

    // Wait for every point to arrive, then let a pending slide search finish
    task automatic drain();
        wait (byte_fifo.size() == 0 && !in_valid && points_due.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Queue one frame; fill: 0 random, 1 all zero, 2 all ones
    task automatic push_frame(int fill, bit damage, int keep);
        logic [7:0] f [FRAME_BYTES];
        logic [14:0] cs;
        for (int i = 0; i < FRAME_BYTES; i++)
            f[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
        for (int i = 0; i < 4; i++) f[i] = hdr[i];
        // now and then plant a header inside the payload
        if (fill == 0 && $urandom_range(0, 3) == 0)
            for (int i = 0; i < 4; i++) f[12 + i] = hdr[i];
        cs = fold_sum(f);
        f[26] = cs[7:0];
        f[27] = {1'b0, cs[14:8]};
        if (damage) f[$urandom_range(4, 27)] ^= 8'(1 << $urandom_range(0, 7));
        for (int i = 0; i < keep; i++) byte_fifo.push_back(f[i]);
    endtask

    task automatic random_traffic(int n_bytes);
        int start;
        start = byte_fifo.size();
        while (byte_fifo.size() - start < n_bytes) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_frame(0, 0, FRAME_BYTES);
                6: push_frame(0, 1, FRAME_BYTES);
                7: push_frame(0, 0, $urandom_range(1, 27));
                8: repeat ($urandom_range(1, 6)) byte_fifo.push_back(8'($urandom));
                default: begin
                    byte_fifo.push_back(hdr[0]);
                    byte_fifo.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        hdr[0] = 8'h55; hdr[1] = 8'hAA; hdr[2] = 8'h02; hdr[3] = 8'h08;
        inv_mask = 16'h8000; dist_mask = 16'h3FFF;
        held_fill = 0; resync_total = 0; bad_total = 0;
        for (int i = 0; i < FRAME_BYTES; i++) held[i] = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, extremes, prefix breaks, bad checksum
        burst = 1;
        push_frame(1, 0, FRAME_BYTES);
        push_frame(2, 0, FRAME_BYTES);
        for (int p = 0; p < 4; p++) begin
            for (int i = 0; i < p; i++) byte_fifo.push_back(hdr[i]);
            byte_fifo.push_back(p == 0 ? 8'h00 : hdr[0]);
        end
        byte_fifo.push_back(8'hFF);
        push_frame(0, 1, FRAME_BYTES);
        push_frame(0, 0, FRAME_BYTES);
        drain();

        // register extremes: all zero header, masks fully open and closed
        configure(8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 16'h0000);
        burst = 0;
        random_traffic(60);
        drain();

        configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF);
        push_frame(2, 0, FRAME_BYTES);
        random_traffic(60);
        drain();

        // long receiver hold-off while bytes keep coming
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
        hold_token++;
        burst = 1;
        random_traffic(40);
        drain();
        burst = 0;
        random_traffic(40);
        drain();

        configure(8'h55, 8'hAA, 8'h02, 8'h08, 16'h8000, 16'h3FFF);
        random_traffic(60);
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
